// ===== sv/aabb_pkg.sv =====
// Shared constants and types for the box collision finder.
`timescale 1ns / 1ps

package aabb_pkg;

    localparam int KIND_W  = 2;
    localparam int ID_W    = 16;
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int CNT_W   = 4;   // list fill count and slot addresses

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCAN   = 2'd2;

    typedef struct packed {
        logic        [ID_W-1:0]    id;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic        [SIZE_W-1:0]  width;
        logic        [SIZE_W-1:0]  height;
    } t_box;

    // controller to datapath
    typedef struct packed {
        logic             wr_en;
        logic [CNT_W-1:0] wr_addr;
        logic             rd_en;
        logic [CNT_W-1:0] rd_i;
        logic [CNT_W-1:0] rd_j;
        logic             flush;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic s1_vld;
        logic stall;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/aabb_if.sv =====
// Valid/ready channel interfaces for box items and collision results.
`timescale 1ns / 1ps

interface aabb_in_if
    import aabb_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic        [KIND_W-1:0]  kind;
    logic        [ID_W-1:0]    object_id;
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] top_y;
    logic        [SIZE_W-1:0]  box_width;
    logic        [SIZE_W-1:0]  box_height;

    modport source (
        output valid, kind, object_id, left_x, top_y, box_width, box_height,
        input  ready
    );
    modport sink (
        input  valid, kind, object_id, left_x, top_y, box_width, box_height,
        output ready
    );
endinterface

interface aabb_out_if
    import aabb_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] first_id;
    logic [ID_W-1:0] second_id;
    logic            hit;
    logic            last;

    modport source (
        output valid, first_id, second_id, hit, last,
        input  ready
    );
    modport sink (
        input  valid, first_id, second_id, hit, last,
        output ready
    );
endinterface

// ===== sv/aabb_ctrl.sv =====
// Controller: list fill count, pair walk and scan sequencing.
`timescale 1ns / 1ps

module aabb_ctrl
    import aabb_pkg::*;
#(
    parameter int MAX_OBJECTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [KIND_W-1:0] i_kind,
    output logic              o_ready,
    input  t_sts              i_sts,
    output t_cmd              o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FLUSH
    } t_state;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_OBJECTS);

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_j;
    logic             r_ready;

    logic             w_accept;
    logic             w_full;
    logic             w_j_end;
    logic             w_i_end;

    assign w_accept = i_valid && r_ready;
    assign w_full   = (r_count >= MAX_CNT);
    assign w_j_end  = (r_j == r_count - CNT_W'(1));
    assign w_i_end  = (r_i == r_count - CNT_W'(2));
    assign o_ready  = r_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.wr_en   = w_accept && (i_kind == KIND_APPEND) && !w_full;
        o_cmd.wr_addr = r_count;
        o_cmd.rd_en   = (r_state == ST_SCAN) && !i_sts.stall;
        o_cmd.rd_i    = r_i;
        o_cmd.rd_j    = r_j;
        o_cmd.flush   = (r_state == ST_FLUSH) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_ready <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_ready <= 1'b1;
                    if (w_accept) begin
                        priority if (i_kind == KIND_CLEAR) begin
                            r_count <= '0;
                        end else if (i_kind == KIND_APPEND) begin
                            if (!w_full) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                        end else if (i_kind == KIND_SCAN) begin
                            r_ready <= 1'b0;
                            r_i     <= '0;
                            r_j     <= CNT_W'(1);
                            // fewer than two boxes: no pairs to walk
                            r_state <= (r_count < CNT_W'(2)) ? ST_FLUSH : ST_SCAN;
                        end else begin
                            r_count <= r_count;
                        end
                    end
                end
                ST_SCAN: begin
                    if (!i_sts.stall) begin
                        if (w_j_end) begin
                            if (w_i_end) begin
                                r_state <= ST_DRAIN;
                            end else begin
                                r_i <= r_i + CNT_W'(1);
                                r_j <= r_i + CNT_W'(2);
                            end
                        end else begin
                            r_j <= r_j + CNT_W'(1);
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!i_sts.s1_vld) begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_no_read_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.rd_en && i_sts.stall))
        else $error("pair read issued while pipeline stalled");

    a_flush_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.flush |-> !i_sts.s1_vld)
        else $error("scan closed with a pair test in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("list count beyond capacity");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (r_i < r_j) && (r_j < r_count))
        else $error("pair indices out of order or beyond the list");

endmodule

// ===== sv/aabb_dp.sv =====
// Datapath: box store, pair read stage, overlap test, pending pair and output register.
`timescale 1ns / 1ps

module aabb_dp
    import aabb_pkg::*;
#(
    parameter int MAX_OBJECTS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_box i_wr_box,
    output t_sts o_sts,
    aabb_out_if.source o_out
);

    localparam int IDX_W = $clog2(MAX_OBJECTS);
    localparam int EXT_W = COORD_W + 2;

    t_box r_mem [MAX_OBJECTS];

    t_box            r_a;
    t_box            r_b;
    logic            r_s1_vld;
    logic            r_pend_vld;
    logic [ID_W-1:0] r_pend_first;
    logic [ID_W-1:0] r_pend_second;
    logic            r_out_vld;
    logic [ID_W-1:0] r_out_first;
    logic [ID_W-1:0] r_out_second;
    logic            r_out_hit;
    logic            r_out_last;

    logic signed [EXT_W-1:0] w_ax, w_ay, w_aw, w_ah;
    logic signed [EXT_W-1:0] w_bx, w_by, w_bw, w_bh;
    logic                    w_overlap;
    logic                    w_s1_hit;
    logic                    w_out_free;
    logic                    w_stall;
    logic                    w_push;

    // exact 18-bit sums, strict compares
    always_comb begin
        w_ax = EXT_W'(r_a.left);
        w_ay = EXT_W'(r_a.top);
        w_aw = $signed({3'b000, r_a.width});
        w_ah = $signed({3'b000, r_a.height});
        w_bx = EXT_W'(r_b.left);
        w_by = EXT_W'(r_b.top);
        w_bw = $signed({3'b000, r_b.width});
        w_bh = $signed({3'b000, r_b.height});
        w_overlap = ((w_ax + w_aw) > w_bx) && (w_ax < (w_bx + w_bw)) &&
                    ((w_ay - w_ah) < w_by) && (w_ay > (w_by - w_bh));
    end

    assign w_s1_hit   = r_s1_vld && w_overlap;
    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_stall    = w_s1_hit && r_pend_vld && !w_out_free;
    assign w_push     = w_s1_hit && r_pend_vld && w_out_free;

    assign o_sts.s1_vld   = r_s1_vld;
    assign o_sts.stall    = w_stall;
    assign o_sts.out_free = w_out_free;

    assign o_out.valid     = r_out_vld;
    assign o_out.first_id  = r_out_first;
    assign o_out.second_id = r_out_second;
    assign o_out.hit       = r_out_hit;
    assign o_out.last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr[IDX_W-1:0]] <= i_wr_box;
        end
        if (i_cmd.rd_en) begin
            r_a <= r_mem[i_cmd.rd_i[IDX_W-1:0]];
            r_b <= r_mem[i_cmd.rd_j[IDX_W-1:0]];
        end
    end

    // a found pair is held back until the next one shows it was not the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.rd_en) begin
                r_s1_vld <= 1'b1;
            end else if (!w_stall) begin
                r_s1_vld <= 1'b0;
            end

            if (w_s1_hit && !w_stall) begin
                r_pend_vld    <= 1'b1;
                r_pend_first  <= r_a.id;
                r_pend_second <= r_b.id;
            end else if (i_cmd.flush) begin
                r_pend_vld <= 1'b0;
            end

            if (w_push) begin
                r_out_vld    <= 1'b1;
                r_out_first  <= r_pend_first;
                r_out_second <= r_pend_second;
                r_out_hit    <= 1'b1;
                r_out_last   <= 1'b0;
            end else if (i_cmd.flush) begin
                r_out_vld    <= 1'b1;
                r_out_first  <= r_pend_vld ? r_pend_first : '0;
                r_out_second <= r_pend_vld ? r_pend_second : '0;
                r_out_hit    <= r_pend_vld;
                r_out_last   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    a_push_flush_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && i_cmd.flush))
        else $error("pair push and scan close in the same cycle");

    a_stall_holds_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> r_s1_vld && $stable(r_a) && $stable(r_b))
        else $error("stalled pair test lost");

    a_no_hit_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_hit) |-> r_out_last)
        else $error("empty scan result not marked last");

    a_flush_clears_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> !r_pend_vld)
        else $error("pending pair survives scan close");

endmodule

// ===== sv/aabb_pairwise_collision_finder.sv =====
// Top level of the all-pairs box overlap finder.
//
//   channel  | dir | port  | transaction
//   ---------+-----+-------+-----------------------------------------------
//   item     | in  | i_in  | clear list, append box or start a scan
//   result   | out | o_out | one overlapping id pair, or a no-hit marker
//
// Clear and append leave the block ready, so it keeps taking items.
// A scan of N boxes issues N*(N-1)/2 pair reads, one per cycle from the two-port
// read of the box store unless the walk is stalled, then drains the test stage
// and closes; with fewer than two boxes the scan goes straight to the close.
// Results leave through an output register; a hit that finds it full while a pair
// is already pending stalls the pair walk, and the close waits for it too.
// Reset (synchronous, active low) empties the list; box contents need no reset.
`timescale 1ns / 1ps

module aabb_pairwise_collision_finder
    import aabb_pkg::*;
#(
    parameter int MAX_OBJECTS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    aabb_in_if.sink    i_in,
    aabb_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    t_box w_wr_box;
    logic w_ready;

    assign w_wr_box.id     = i_in.object_id;
    assign w_wr_box.left   = i_in.left_x;
    assign w_wr_box.top    = i_in.top_y;
    assign w_wr_box.width  = i_in.box_width;
    assign w_wr_box.height = i_in.box_height;
    assign i_in.ready      = w_ready;

    aabb_ctrl #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_kind  (i_in.kind),
        .o_ready (w_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    aabb_dp #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_wr_box (w_wr_box),
        .o_sts    (w_sts),
        .o_out    (o_out)
    );

endmodule
